// ----- rtl/core/nqs_pkg.sv -----
// Package: shared constants and controller/datapath interface types for the N-queens unit.
package nqs_pkg;

    localparam int MAX_BOARD_DEF = 16;
    localparam int ROW_W         = 4;
    localparam int SIZE_W        = 5;
    localparam int COUNT_W       = 24;
    localparam int PACK_W        = 64;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 3;
    localparam int REG_IDX_W     = 1;

    localparam logic [SIZE_W-1:0]    BOARD_RESET = SIZE_W'(11);
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [REG_IDX_W-1:0] REG_BOARD_SIZE = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic clear;         // drop all search state
        logic start_search;  // new transaction: optional restart, set up resume point
        logic step;          // one placement try or one backtrack
        logic emit;          // load result registers
    } nqs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;   // search already exhausted
        logic found;  // this step completed a solution
        logic fail;   // this step exhausted the search
    } nqs_stat_t;

endpackage

// ----- rtl/core/nqs_ctrl.sv -----
// Controller: sequences one transaction through setup, search steps and result.
module nqs_ctrl
    import nqs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      cfg_clear,
    input  nqs_stat_t stat,
    output nqs_cmd_t  cmd,
    output logic      busy,
    output logic      result_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.clear = cfg_clear;
                if (start) begin
                    cmd.start_search = 1'b1;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (stat.done) begin
                    state_next = ST_RESULT;
                end
                else begin
                    cmd.step = 1'b1;
                    if (stat.found || stat.fail) begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == ST_RESULT);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

// ----- rtl/core/nqs_datapath.sv -----
// Datapath: queen placement registers, occupancy masks, step logic and result registers.
module nqs_datapath
    import nqs_pkg::*;
#(
    parameter int MAX_BOARD = MAX_BOARD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  nqs_cmd_t           cmd,
    input  logic               restart,
    input  logic [SIZE_W-1:0]  size,
    output nqs_stat_t          stat,
    output logic [PACK_W-1:0]  rows_packed,
    output logic [COUNT_W-1:0] solution_number,
    output logic               exhausted
);

    localparam int IDX_W  = $clog2(MAX_BOARD);
    localparam int DIAG_W = 2 * MAX_BOARD - 1;
    localparam int DIDX_W = $clog2(DIAG_W);
    localparam int SUM_W  = DIDX_W + 1;

    logic [ROW_W-1:0]   qrows_reg [MAX_BOARD];
    logic [SIZE_W-1:0]  col_reg, col_next;
    logic [SIZE_W-1:0]  row_reg, row_next;
    logic [MAX_BOARD-1:0] rows_used_reg, rows_used_next;
    logic [DIAG_W-1:0]  rise_reg, rise_next;
    logic [DIAG_W-1:0]  fall_reg, fall_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               sdone_reg, sdone_next;

    logic [PACK_W-1:0]  pack_reg;
    logic [COUNT_W-1:0] num_reg;
    logic               exh_reg;

    logic [SIZE_W-1:0]  bcol, tcol, trow;
    logic [ROW_W-1:0]   prow;
    logic [SUM_W-1:0]   rise_sum, fall_sum;
    logic [MAX_BOARD-1:0] row_m;
    logic [DIAG_W-1:0]  rise_m, fall_m;
    logic               row_over, is_free, wr_en, found, fail;
    logic [PACK_W-1:0]  packed_rows;

    // square under test: the backtrack target when the row ran off the board
    always_comb begin
        row_over = (row_reg >= size);
        bcol     = col_reg - SIZE_W'(1);
        prow     = qrows_reg[bcol[IDX_W-1:0]];
        tcol     = row_over ? bcol : col_reg;
        trow     = row_over ? SIZE_W'(prow) : row_reg;
        rise_sum = SUM_W'(tcol) + SUM_W'(trow);
        fall_sum = SUM_W'(tcol) + SUM_W'(MAX_BOARD - 1) - SUM_W'(trow);
        row_m    = MAX_BOARD'(1) << trow[IDX_W-1:0];
        rise_m   = DIAG_W'(1) << rise_sum[DIDX_W-1:0];
        fall_m   = DIAG_W'(1) << fall_sum[DIDX_W-1:0];
        is_free  = ((rows_used_reg & row_m) == '0) &&
                   ((rise_reg & rise_m) == '0) &&
                   ((fall_reg & fall_m) == '0);
        // outcome of a step taken from the current registers
        fail     = row_over && (col_reg == '0);
        found    = !row_over && is_free && ((col_reg + SIZE_W'(1)) == size);
    end

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        rows_used_next = rows_used_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        count_next     = count_reg;
        sdone_next     = sdone_reg;
        wr_en          = 1'b0;
        if (cmd.clear || (cmd.start_search && restart)) begin
            col_next       = '0;
            row_next       = '0;
            rows_used_next = '0;
            rise_next      = '0;
            fall_next      = '0;
            count_next     = '0;
            sdone_next     = 1'b0;
        end
        else if (cmd.start_search) begin
            // resuming after a solution: force a backtrack out of the last column
            row_next = (col_reg == size) ? size : '0;
        end
        else if (cmd.step && !sdone_reg) begin
            if (row_over) begin
                if (col_reg == '0) begin
                    sdone_next     = 1'b1;
                    col_next       = '0;
                    row_next       = '0;
                    rows_used_next = '0;
                    rise_next      = '0;
                    fall_next      = '0;
                end
                else begin
                    col_next       = bcol;
                    row_next       = SIZE_W'(prow) + SIZE_W'(1);
                    rows_used_next = rows_used_reg ^ row_m;
                    rise_next      = rise_reg ^ rise_m;
                    fall_next      = fall_reg ^ fall_m;
                end
            end
            else if (is_free) begin
                wr_en          = 1'b1;
                rows_used_next = rows_used_reg ^ row_m;
                rise_next      = rise_reg ^ rise_m;
                fall_next      = fall_reg ^ fall_m;
                col_next       = col_reg + SIZE_W'(1);
                row_next       = '0;
            end
            else begin
                row_next = row_reg + SIZE_W'(1);
            end
        end
        else if (cmd.emit && !sdone_reg && (count_reg != COUNT_MAX)) begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        packed_rows = '0;
        for (int k = 0; k < MAX_BOARD; k++) begin
            if (SIZE_W'(k) < size) begin
                packed_rows[ROW_W*k +: ROW_W] = qrows_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            col_reg       <= '0;
            row_reg       <= '0;
            rows_used_reg <= '0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            count_reg     <= '0;
            sdone_reg     <= 1'b0;
        end
        else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            rows_used_reg <= rows_used_next;
            rise_reg      <= rise_next;
            fall_reg      <= fall_next;
            count_reg     <= count_next;
            sdone_reg     <= sdone_next;
        end
    end

    // placements and result registers hold payload only
    always_ff @(posedge clk) begin
        if (wr_en) begin
            qrows_reg[col_reg[IDX_W-1:0]] <= row_reg[ROW_W-1:0];
        end
        if (cmd.emit) begin
            pack_reg <= sdone_reg ? '0 : packed_rows;
            num_reg  <= count_reg;
            exh_reg  <= sdone_reg;
        end
    end

    assign stat.done       = sdone_reg;
    assign stat.found      = found;
    assign stat.fail       = fail;
    assign rows_packed     = pack_reg;
    assign solution_number = num_reg;
    assign exhausted       = exh_reg;

endmodule

// ----- rtl/core/n_queens_solution_generator_unit.sv -----
// Top level: N-queens solution generator with APB register port.
//
// Usage
//   Request a transaction by raising start while busy is low; restart=1 first
//   drops the search and begins again from the first placement. Each
//   transaction produces exactly one result: rows_packed (4-bit row per
//   column, column 0 in the low nibble), solution_number and exhausted, shown
//   for a single cycle with result_valid high. The receiver cannot stall;
//   the result must be captured in that cycle.
// Search steps
//   A transaction steps the search until a solution or exhaustion. A step is one
//   placement try in the current column or one backtrack, done by a single
//   shared step unit in the datapath, so latency tracks the backtracking
//   work between consecutive solutions. A request on an already exhausted
//   search answers without taking a step. Only one transaction is in flight;
//   start is taken again on the cycle result_valid is high.
// Configuration
//   Register 0 at byte address 0: board_size (5 bits, reset 11). 0 acts as
//   1, values above MAX_BOARD act as MAX_BOARD. A write while idle also
//   clears the search state. Writes elsewhere are ignored and read back zero.
// Reset
//   rst_n clears the search, the solution count and board_size to 11.
module n_queens_solution_generator_unit
    import nqs_pkg::*;
#(
    parameter int MAX_BOARD = MAX_BOARD_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic               restart,
    // result channel
    output logic               result_valid,
    output logic [PACK_W-1:0]  rows_packed,
    output logic [COUNT_W-1:0] solution_number,
    output logic               exhausted,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [SIZE_W-1:0]    board_size_reg;
    logic [SIZE_W-1:0]    size_eff;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 apb_wr;
    logic                 cfg_clear;
    nqs_cmd_t             cmd;
    nqs_stat_t            stat;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign apb_wr  = psel && penable && pwrite;

    // only the board size register exists; a write to it also resets the search while idle
    assign cfg_clear = apb_wr && (reg_idx == REG_BOARD_SIZE);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            board_size_reg <= BOARD_RESET;
        end
        else if (cfg_clear) begin
            board_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BOARD_SIZE: prdata = DATA_W'(board_size_reg);
            default:        prdata = '0;
        endcase
    end

    // clamp into 1..MAX_BOARD
    always_comb begin
        if (board_size_reg == '0) begin
            size_eff = SIZE_W'(1);
        end
        else if (board_size_reg > SIZE_W'(MAX_BOARD)) begin
            size_eff = SIZE_W'(MAX_BOARD);
        end
        else begin
            size_eff = board_size_reg;
        end
    end

    nqs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cfg_clear    (cfg_clear),
        .stat         (stat),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    nqs_datapath #(
        .MAX_BOARD (MAX_BOARD)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .restart         (restart),
        .size            (size_eff),
        .stat            (stat),
        .rows_packed     (rows_packed),
        .solution_number (solution_number),
        .exhausted       (exhausted)
    );

endmodule

// ----- rtl/core/nqs_checker.sv -----
// Checker: port-level assertions for the N-queens unit, bound to the top level.
module nqs_checker
    import nqs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              result_valid,
    input logic [PACK_W-1:0] rows_packed,
    input logic              exhausted
);

    // one transaction in flight: an accepted request makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the result strobe is never held high
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // the end of busy always delivers a result
    a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("busy dropped without a result");

    a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && exhausted) |-> (rows_packed == '0))
        else $error("exhausted result carries a placement");

endmodule

bind n_queens_solution_generator_unit nqs_checker u_nqs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .rows_packed  (rows_packed),
    .exhausted    (exhausted)
);

// ----- tb/nqs_solution_monitor.sv -----
// Monitor for the N-queens unit: predicts each solution transaction and checks results and reads.
`timescale 1ns / 100ps

module nqs_solution_monitor
    import nqs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               restart,
    input  logic               result_valid,
    input  logic [PACK_W-1:0]  rows_packed,
    input  logic [COUNT_W-1:0] solution_number,
    input  logic               exhausted,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic [DATA_W-1:0]  prdata,
    input  logic               pready,
    output logic               drained,
    output int unsigned        fail_count
);

    localparam int NB = MAX_BOARD_DEF;

    typedef struct {
        logic [PACK_W-1:0]  rows;
        logic [COUNT_W-1:0] ordinal;
        logic               none_left;
    } solution_t;

    // mirrored search state
    logic [SIZE_W-1:0]   board;
    logic [ROW_W-1:0]    queen_row [NB];
    int unsigned         placed;
    logic [NB-1:0]       rows_taken;
    logic [2*NB-2:0]     rise_taken;
    logic [2*NB-2:0]     fall_taken;
    logic [COUNT_W-1:0]  found;
    bit                  search_over;

    solution_t           solutions_due[$];
    int unsigned         backlog;

    assign drained = (backlog == 0);

    function automatic int unsigned span();
        if (board == '0)
            return 1;
        if (board > NB)
            return NB;
        return board;
    endfunction

    function automatic void drop_queens();
        for (int k = 0; k < NB; k++)
            queen_row[k] = '0;
        placed     = 0;
        rows_taken = '0;
        rise_taken = '0;
        fall_taken = '0;
    endfunction

    function automatic void wipe_search();
        drop_queens();
        found       = '0;
        search_over = 1'b0;
    endfunction

    function automatic void flip(int c, int r);
        rows_taken[r]          = ~rows_taken[r];
        rise_taken[c + r]      = ~rise_taken[c + r];
        fall_taken[c + NB-1-r] = ~fall_taken[c + NB-1-r];
    endfunction

    // resume depth-first search; 0 when no placement remains
    function automatic bit seek_next(int n);
        int c;
        int r;
        if (placed >= n) begin
            c = n - 1;
            r = queen_row[c];
            flip(c, r);
            r++;
        end
        else begin
            c = placed;
            r = 0;
        end
        while (1) begin
            if (r >= n) begin
                if (c == 0)
                    return 1'b0;
                c--;
                r = queen_row[c];
                flip(c, r);
                r++;
            end
            else if (!rows_taken[r] && !rise_taken[c + r] && !fall_taken[c + NB-1-r]) begin
                queen_row[c] = ROW_W'(r);
                flip(c, r);
                c++;
                if (c == n) begin
                    placed = c;
                    return 1'b1;
                end
                r = 0;
            end
            else
                r++;
        end
        return 1'b0;
    endfunction

    function automatic solution_t next_solution(logic again);
        solution_t   s;
        int unsigned n;
        n = span();
        if (again)
            wipe_search();
        if (!search_over && !seek_next(n)) begin
            search_over = 1'b1;
            drop_queens();
        end
        s.rows      = '0;
        s.ordinal   = found;
        s.none_left = search_over;
        if (!search_over) begin
            for (int k = 0; k < n; k++)
                s.rows[ROW_W*k +: ROW_W] = queen_row[k];
            if (found != COUNT_MAX)
                found = found + 1'b1;
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        solution_t         want;
        logic [DATA_W-1:0] reg_want;
        int unsigned       pushed;
        int unsigned       popped;
        if (!rst_n) begin
            board = BOARD_RESET;
            wipe_search();
            solutions_due.delete();
            backlog    <= 0;
            fail_count = 0;
        end
        else begin
            pushed = 0;
            popped = 0;
            if (result_valid) begin
                if (solutions_due.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_count++;
                end
                else begin
                    want   = solutions_due.pop_front();
                    popped = 1;
                    if (rows_packed !== want.rows) begin
                        $error("rows_packed: expected %h, got %h", want.rows, rows_packed);
                        fail_count++;
                    end
                    if (solution_number !== want.ordinal) begin
                        $error("solution_number: expected %0d, got %0d",
                               want.ordinal, solution_number);
                        fail_count++;
                    end
                    if (exhausted !== want.none_left) begin
                        $error("exhausted: expected %b, got %b", want.none_left, exhausted);
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[ADDR_W-1:2] == REG_BOARD_SIZE) begin
                        board = pwdata[SIZE_W-1:0];
                        wipe_search();
                    end
                end
                else begin
                    reg_want = (paddr[ADDR_W-1:2] == REG_BOARD_SIZE) ? DATA_W'(board) : '0;
                    if (prdata !== reg_want) begin
                        $error("prdata: expected %h, got %h", reg_want, prdata);
                        fail_count++;
                    end
                end
            end
            if (start && !busy) begin
                solutions_due.push_back(next_solution(restart));
                pushed = 1;
            end
            backlog <= backlog + pushed - popped;
        end
    end

endmodule

// ----- tb/tb_n_queens_solution_generator_unit.sv -----
// Testbench top for the N-queens unit: reset, directed and random solution requests, verdict.
`timescale 1ns / 100ps

module tb_n_queens_solution_generator_unit;
    import nqs_pkg::*;

    // idle cycles with no request, result or register access before giving up; a 16-queen
    // board needs on the order of 1e5 steps to reach its first solution
    localparam int unsigned STALL_LIMIT = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 480;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               restart = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;

    logic               busy;
    logic               result_valid;
    logic [PACK_W-1:0]  rows_packed;
    logic [COUNT_W-1:0] solution_number;
    logic               exhausted;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    logic               drained;
    int unsigned        fail_count;

    // sender behavior
    bit                 steady;       // phase with back-to-back requests
    int unsigned        issued;
    int unsigned        stall_cycles = 0;

    // solutions per board size, for sizing the small-board phases so they
    // run past the last solution into exhaustion
    int unsigned        small_sols [9] = '{1, 1, 0, 0, 2, 10, 4, 40, 92};

    always #6 clk = ~clk;

    n_queens_solution_generator_unit DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .restart         (restart),
        .result_valid    (result_valid),
        .rows_packed     (rows_packed),
        .solution_number (solution_number),
        .exhausted       (exhausted),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    nqs_solution_monitor u_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .restart         (restart),
        .result_valid    (result_valid),
        .rows_packed     (rows_packed),
        .solution_number (solution_number),
        .exhausted       (exhausted),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .drained         (drained),
        .fail_count      (fail_count)
    );

    // Watchdog: any request, result or register access counts as progress.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // APB access: setup cycle, then access cycle held until pready.
    task automatic cfg_access(input bit wr, input int unsigned idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // board_size write with junk in the unused upper bits
    task automatic set_board(input int unsigned size);
        cfg_access(1'b1, REG_BOARD_SIZE, ($urandom() & ~32'h1F) | DATA_W'(size & 32'h1F));
    endtask

    // One solution transaction. start stays high across back-to-back
    // requests; it drops only for a sender gap or when drain() stops requesting.
    task automatic request(input bit again);
        int unsigned pick;
        int unsigned gap;
        pick = $urandom_range(0, 99);
        if (steady || pick < 50)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(4, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        restart <= again;
        do
            @(posedge clk);
        while (busy);
        issued++;
    endtask

    // Stop requesting and wait for every outstanding result.
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (!drained);
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned size;
        int unsigned count;
        issued = 0;
        steady = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // reset board (11): read back, a few solutions, then a restart
        cfg_access(1'b0, REG_BOARD_SIZE, '0);
        repeat (3) request(1'b0);
        request(1'b1);
        drain();

        // single square: one solution, then exhausted, and it stays exhausted
        set_board(1);
        repeat (3) request(1'b0);
        drain();

        // boards with no solution report exhaustion at once with count 0
        set_board(2);
        request(1'b0);
        drain();
        set_board(3);
        request(1'b0);
        drain();

        // 4x4: both solutions, exhaustion, restart after exhaustion
        steady = 1'b1;
        set_board(4);
        repeat (4) request(1'b0);
        request(1'b1);
        drain();
        steady = 1'b0;

        // size 0 behaves as 1
        set_board(0);
        repeat (2) request(1'b0);
        drain();

        // oversize clamps to 16; a write to an unmapped register must not
        // disturb the search, and reads back zero
        set_board(31);
        repeat (2) request(1'b0);
        drain();
        cfg_access(1'b1, 1, 32'hFFFF_FFFF);
        cfg_access(1'b0, 1, '0);
        cfg_access(1'b0, REG_BOARD_SIZE, '0);
        request(1'b0);
        drain();

        // largest legal board
        set_board(16);
        request(1'b0);
        drain();

        // --- random phases ---
        // Mostly small boards run into exhaustion; mid-size boards walk deep
        // into the search; size 0 and 13 now and then. Large boards are kept
        // out of the random part because of their long backtracking searches.
        while (issued < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                size  = $urandom_range(1, 8);
                count = $urandom_range(1, small_sols[size] + 3);
            end
            else if (pick < 88) begin
                size  = $urandom_range(9, 12);
                count = $urandom_range(5, 25);
            end
            else if (pick < 95) begin
                size  = 0;
                count = $urandom_range(1, 4);
            end
            else begin
                size  = 13;
                count = $urandom_range(2, 6);
            end
            // occasionally keep the previous board and resume its search
            if ($urandom_range(0, 5) != 0)
                set_board(size);
            if ($urandom_range(0, 3) == 0)
                cfg_access(1'b0, $urandom_range(0, 1), '0);
            steady = ($urandom_range(0, 3) == 0);
            repeat (count) request($urandom_range(0, 99) < 8);
            drain();
        end

        // wait quietly to catch any stray result strobe
        repeat (10) @(posedge clk);
        if (fail_count == 0 && drained)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
